// ===== design/sssp_pkg.sv =====
// ----------------------------------------------------------------------------
// Shortest paths package
// Shared types and constants of the single-source shortest paths unit.
// ----------------------------------------------------------------------------
package sssp_pkg;

  localparam int unsigned VID_W  = 6;
  localparam int unsigned DIST_W = 22;
  localparam int unsigned CFG_W  = 7;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic signed [DIST_W-1:0] DIST_MIN = {1'b1, {(DIST_W-1){1'b0}}};
  localparam logic signed [DIST_W-1:0] DIST_MAX = {1'b0, {(DIST_W-1){1'b1}}};

  localparam logic [CFG_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  localparam logic REG_VERTEX_COUNT = 1'b0;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_RUN    = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_VTX_RD,
    ST_RELAX,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic                     reached;
    logic                     has_pred;
    logic [VID_W-1:0]         pred;
    logic signed [DIST_W-1:0] distance;
  } vtx_t;

endpackage

// ===== design/single_source_shortest_paths_unit.sv =====
// ----------------------------------------------------------------------------
// Single-source shortest paths unit
// Clear and append transactions are accepted only in the idle state. A run of n
// vertices over E stored edges first initializes the vertex memory, then makes
// n-1 relaxation passes (a read state and a relax state per edge; none when n is 1
// or no edge is stored), then emits each result through a read and a load state.
// Reset empties the edge table and sets the vertex count to 64.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_unit import sssp_pkg::*; #(
  parameter int unsigned MAX_VERTICES = 64,
  parameter int unsigned MAX_EDGES    = 256,
  parameter int unsigned WEIGHT_BITS  = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [ADDR_W-1:0]        paddr,
  input  logic [DATA_W-1:0]        pwdata,
  output logic [DATA_W-1:0]        prdata,
  output logic                     pready,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               opcode_i,
  input  logic [VID_W-1:0]         edge_from_i,
  input  logic [VID_W-1:0]         edge_to_i,
  input  logic signed [15:0]       edge_weight_i,
  input  logic [VID_W-1:0]         start_vertex_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [VID_W-1:0]         vertex_index_o,
  output logic signed [DIST_W-1:0] distance_o,
  output logic [VID_W-1:0]         predecessor_o,
  output logic                     has_predecessor_o,
  output logic                     reached_o,
  output logic                     last_o
);

  localparam int unsigned VW     = $clog2(MAX_VERTICES);
  localparam int unsigned VCNT_W = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EW     = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW    = $clog2(MAX_EDGES + 1);
  localparam int unsigned EDGE_W = 2 * VID_W + WEIGHT_BITS;

  state_e             state_q, state_d;
  logic [CFG_W-1:0]   vertex_count_q;
  logic [ECW-1:0]     edges_q, edges_d;
  logic [VCNT_W-1:0]  n_q, n_d;
  logic [VID_W-1:0]   start_q, start_d;
  logic [VCNT_W-1:0]  v_q, v_d;
  logic [ECW-1:0]     e_q, e_d;
  logic [VCNT_W-1:0]  pass_q, pass_d;

  logic [EDGE_W-1:0]  edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0]  edge_rd_q;
  logic               edge_we;

  vtx_t               vtx_mem [MAX_VERTICES];
  vtx_t               rd_a_q, rd_b_q;
  logic [VW-1:0]      raddr_a;
  logic               vtx_we;
  logic [VW-1:0]      vtx_waddr;
  vtx_t               vtx_wdata;

  logic [VID_W-1:0]             e_from, e_to;
  logic signed [WEIGHT_BITS-1:0] e_weight;
  logic                          relax_upd;
  vtx_t                          relax_vtx;

  logic               in_acc, cfg_we, out_free, out_load;
  logic [VCNT_W-1:0]  eff_count;
  logic [VCNT_W-1:0]  n_minus_one;

  logic                     out_valid_q;
  logic [VID_W-1:0]         out_index_q;
  vtx_t                     out_vtx_q;
  logic                     out_last_q;

  assign pready     = 1'b1;
  assign prdata     = DATA_W'(vertex_count_q);
  assign cfg_we     = psel && penable && pwrite && (paddr[2] == REG_VERTEX_COUNT);
  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign n_minus_one = VCNT_W'(n_q - 1'b1);

  assign e_from   = edge_rd_q[EDGE_W-1 -: VID_W];
  assign e_to     = edge_rd_q[EDGE_W-VID_W-1 -: VID_W];
  assign e_weight = edge_rd_q[WEIGHT_BITS-1:0];

  always_comb begin
    if (vertex_count_q == '0) begin
      eff_count = VCNT_W'(1);
    end else if (vertex_count_q > CFG_W'(MAX_VERTICES)) begin
      eff_count = VCNT_W'(MAX_VERTICES);
    end else begin
      eff_count = VCNT_W'(vertex_count_q);
    end
  end

  sssp_relax #(
    .WEIGHT_BITS(WEIGHT_BITS),
    .VCNT_W     (VCNT_W)
  ) u_relax (
    .src_i   (rd_a_q),
    .dst_i   (rd_b_q),
    .weight_i(e_weight),
    .from_i  (e_from),
    .to_i    (e_to),
    .count_i (n_q),
    .update_o(relax_upd),
    .vtx_o   (relax_vtx)
  );

  always_comb begin
    state_d   = state_q;
    edges_d   = edges_q;
    n_d       = n_q;
    start_d   = start_q;
    v_d       = v_q;
    e_d       = e_q;
    pass_d    = pass_q;
    edge_we   = 1'b0;
    vtx_we    = 1'b0;
    vtx_waddr = v_q[VW-1:0];
    vtx_wdata = '0;
    raddr_a   = v_q[VW-1:0];
    out_load  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_e'(opcode_i))
            OP_CLEAR: begin
              edges_d = '0;
            end
            OP_APPEND: begin
              if (edges_q != ECW'(MAX_EDGES)) begin
                edge_we = 1'b1;
                edges_d = ECW'(edges_q + 1'b1);
              end
            end
            OP_RUN: begin
              n_d     = eff_count;
              start_d = start_vertex_i;
              v_d     = '0;
              state_d = ST_INIT;
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        vtx_we            = 1'b1;
        vtx_wdata.reached = (CFG_W'(start_q) == CFG_W'(v_q));
        if (v_q == n_minus_one) begin
          v_d    = '0;
          e_d    = '0;
          pass_d = '0;
          if ((n_q == VCNT_W'(1)) || (edges_q == '0)) begin
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_VTX_RD;
          end
        end else begin
          v_d = VCNT_W'(v_q + 1'b1);
        end
      end
      ST_VTX_RD: begin
        raddr_a = e_from[VW-1:0];
        state_d = ST_RELAX;
      end
      ST_RELAX: begin
        vtx_we    = relax_upd;
        vtx_waddr = e_to[VW-1:0];
        vtx_wdata = relax_vtx;
        if (e_q == ECW'(edges_q - 1'b1)) begin
          e_d = '0;
          if (pass_q == VCNT_W'(n_q - 2'd2)) begin
            state_d = ST_EMIT_RD;
          end else begin
            pass_d  = VCNT_W'(pass_q + 1'b1);
            state_d = ST_VTX_RD;
          end
        end else begin
          e_d     = ECW'(e_q + 1'b1);
          state_d = ST_VTX_RD;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (out_free) begin
          out_load = 1'b1;
          if (v_q == n_minus_one) begin
            state_d = ST_IDLE;
          end else begin
            v_d     = VCNT_W'(v_q + 1'b1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      vertex_count_q <= VERTEX_COUNT_RESET;
      edges_q        <= '0;
      n_q            <= '0;
      start_q        <= '0;
      v_q            <= '0;
      e_q            <= '0;
      pass_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we) begin
        vertex_count_q <= pwdata[CFG_W-1:0];
      end
      edges_q <= edges_d;
      n_q     <= n_d;
      start_q <= start_d;
      v_q     <= v_d;
      e_q     <= e_d;
      pass_q  <= pass_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_index_q <= VID_W'(v_q);
      out_vtx_q   <= rd_a_q;
      out_last_q  <= (v_q == n_minus_one);
    end
  end

  always_ff @(posedge clk_i) begin
    if (edge_we) begin
      edge_mem[edges_q[EW-1:0]] <= {edge_from_i, edge_to_i, WEIGHT_BITS'(edge_weight_i)};
    end
    edge_rd_q <= edge_mem[e_d[EW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (vtx_we) begin
      vtx_mem[vtx_waddr] <= vtx_wdata;
    end
    rd_a_q <= vtx_mem[raddr_a];
    rd_b_q <= vtx_mem[e_to[VW-1:0]];
  end

  assign out_valid_o       = out_valid_q;
  assign vertex_index_o    = out_index_q;
  assign distance_o        = out_vtx_q.reached ? out_vtx_q.distance : '0;
  assign has_predecessor_o = out_vtx_q.reached && out_vtx_q.has_pred;
  assign predecessor_o     = has_predecessor_o ? out_vtx_q.pred : '0;
  assign reached_o         = out_vtx_q.reached;
  assign last_o            = out_last_q;

endmodule

// ===== design/sssp_relax.sv =====
// ----------------------------------------------------------------------------
// Edge relaxation
// Forms the saturated candidate distance over one edge and decides whether
// the target vertex entry is rewritten.
// ----------------------------------------------------------------------------
module sssp_relax import sssp_pkg::*; #(
  parameter int unsigned WEIGHT_BITS = 16,
  parameter int unsigned VCNT_W      = 7
) (
  input  vtx_t                          src_i,
  input  vtx_t                          dst_i,
  input  logic signed [WEIGHT_BITS-1:0] weight_i,
  input  logic [VID_W-1:0]              from_i,
  input  logic [VID_W-1:0]              to_i,
  input  logic [VCNT_W-1:0]             count_i,
  output logic                          update_o,
  output vtx_t                          vtx_o
);

  localparam int unsigned SUM_W = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  logic signed [SUM_W-1:0]  sum;
  logic signed [DIST_W-1:0] cand;
  logic                     in_range;

  always_comb begin
    sum = SUM_W'(src_i.distance) + SUM_W'(weight_i);
    if (sum < SUM_W'(DIST_MIN)) begin
      cand = DIST_MIN;
    end else if (sum > SUM_W'(DIST_MAX)) begin
      cand = DIST_MAX;
    end else begin
      cand = DIST_W'(sum);
    end
    in_range = (CFG_W'(from_i) < CFG_W'(count_i)) && (CFG_W'(to_i) < CFG_W'(count_i));
    update_o = in_range && src_i.reached && (!dst_i.reached || (dst_i.distance > cand));
    vtx_o.reached  = 1'b1;
    vtx_o.has_pred = 1'b1;
    vtx_o.pred     = from_i;
    vtx_o.distance = cand;
  end

endmodule

// ===== bench/single_source_shortest_paths_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Shortest paths unit testbench
// Drives clear, append and run transactions into the unit and compares every
// vertex result against a shortest-path predictor kept inside the bench. The
// vertex count is changed over the APB port between phases, and both sides
// of the stream insert random idle bursts, plus one long output hold.
// ----------------------------------------------------------------------------
module single_source_shortest_paths_unit_tb;
  import sssp_pkg::*;

  localparam int GRAPH_VERTICES = 64;
  localparam int GRAPH_EDGES    = 256;
  localparam int DRAIN_CYCLES   = 32;
  localparam int HOLD_CYCLES    = 400;

  localparam logic [1:0]        OP_UNUSED         = 2'd3;
  localparam logic [ADDR_W-1:0] VERTEX_COUNT_ADDR = ADDR_W'(4 * REG_VERTEX_COUNT);
  localparam logic [ADDR_W-1:0] SPARE_ADDR        = ADDR_W'(4);

  typedef struct {
    logic [1:0]         op;
    logic [VID_W-1:0]   src;
    logic [VID_W-1:0]   dst;
    logic signed [15:0] weight;
    logic [VID_W-1:0]   start;
  } graph_cmd_t;

  typedef struct {
    logic [VID_W-1:0]         vertex;
    logic signed [DIST_W-1:0] distance;
    logic [VID_W-1:0]         pred;
    logic                     has_pred;
    logic                     reached;
    logic                     last;
  } vertex_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] opcode_i = OP_CLEAR;
  logic [VID_W-1:0] edge_from_i = '0;
  logic [VID_W-1:0] edge_to_i = '0;
  logic signed [15:0] edge_weight_i = '0;
  logic [VID_W-1:0] start_vertex_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [VID_W-1:0] vertex_index_o;
  logic signed [DIST_W-1:0] distance_o;
  logic [VID_W-1:0] predecessor_o;
  logic has_predecessor_o;
  logic reached_o;
  logic last_o;

  logic [VID_W-1:0]   edge_src_mem [GRAPH_EDGES];
  logic [VID_W-1:0]   edge_dst_mem [GRAPH_EDGES];
  logic signed [15:0] edge_wt_mem  [GRAPH_EDGES];
  int                 edges_held = 0;
  logic [CFG_W-1:0]   vertex_cfg = VERTEX_COUNT_RESET;

  graph_cmd_t     pending_cmds[$];
  vertex_result_t expected_vertices[$];
  graph_cmd_t     cur_cmd;

  int mismatch_count = 0;
  int gap_left = 0;
  int stall_left = 0;
  int hold_left = 0;
  bit quiet_phase = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_taken = 1'b0;

  single_source_shortest_paths_unit #(
    .MAX_VERTICES(GRAPH_VERTICES),
    .MAX_EDGES(GRAPH_EDGES),
    .WEIGHT_BITS(16)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .opcode_i(opcode_i),
    .edge_from_i(edge_from_i),
    .edge_to_i(edge_to_i),
    .edge_weight_i(edge_weight_i),
    .start_vertex_i(start_vertex_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .vertex_index_o(vertex_index_o),
    .distance_o(distance_o),
    .predecessor_o(predecessor_o),
    .has_predecessor_o(has_predecessor_o),
    .reached_o(reached_o),
    .last_o(last_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int active_vertices();
    if (vertex_cfg == 0) return 1;
    if (vertex_cfg > GRAPH_VERTICES) return GRAPH_VERTICES;
    return int'(vertex_cfg);
  endfunction

  function automatic void solve_shortest_paths(input logic [VID_W-1:0] start);
    int n;
    int cand;
    int u;
    int t;
    int dist_tab [GRAPH_VERTICES];
    bit hit [GRAPH_VERTICES];
    bit has_pred [GRAPH_VERTICES];
    logic [VID_W-1:0] pred [GRAPH_VERTICES];
    vertex_result_t res;
    n = active_vertices();
    for (int v = 0; v < GRAPH_VERTICES; v++) begin
      dist_tab[v] = 0;
      hit[v] = 1'b0;
      has_pred[v] = 1'b0;
      pred[v] = '0;
    end
    if (int'(start) < n) hit[start] = 1'b1;
    for (int p = 0; p + 1 < n; p++) begin
      for (int e = 0; e < edges_held; e++) begin
        u = int'(edge_src_mem[e]);
        t = int'(edge_dst_mem[e]);
        if (u < n && t < n && hit[u]) begin
          cand = dist_tab[u] + int'(edge_wt_mem[e]);
          if (cand < int'(DIST_MIN)) cand = int'(DIST_MIN);
          else if (cand > int'(DIST_MAX)) cand = int'(DIST_MAX);
          if (!hit[t] || dist_tab[t] > cand) begin
            hit[t] = 1'b1;
            dist_tab[t] = cand;
            has_pred[t] = 1'b1;
            pred[t] = VID_W'(u);
          end
        end
      end
    end
    for (int v = 0; v < n; v++) begin
      res.vertex = VID_W'(v);
      res.reached = hit[v];
      res.distance = hit[v] ? DIST_W'(dist_tab[v]) : '0;
      res.has_pred = hit[v] && has_pred[v];
      res.pred = res.has_pred ? pred[v] : '0;
      res.last = (v + 1 == n);
      expected_vertices.push_back(res);
    end
  endfunction

  function automatic void apply_graph_cmd(input graph_cmd_t cmd);
    case (cmd.op)
      OP_CLEAR: edges_held = 0;
      OP_APPEND: begin
        if (edges_held < GRAPH_EDGES) begin
          edge_src_mem[edges_held] = cmd.src;
          edge_dst_mem[edges_held] = cmd.dst;
          edge_wt_mem[edges_held] = cmd.weight;
          edges_held++;
        end
      end
      OP_RUN: solve_shortest_paths(cmd.start);
      default: ;
    endcase
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin : drive_cmds
    bit next_valid;
    graph_cmd_t next_cmd;
    if (rst_ni) begin
      next_valid = in_valid_i;
      if (in_valid_i && !in_stall_o) begin
        apply_graph_cmd(cur_cmd);
        next_valid = 1'b0;
      end
      if (!next_valid && pending_cmds.size() != 0) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
        end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
          gap_left <= $urandom_range(0, 8);
        end else begin
          next_cmd = pending_cmds.pop_front();
          cur_cmd <= next_cmd;
          opcode_i <= next_cmd.op;
          edge_from_i <= next_cmd.src;
          edge_to_i <= next_cmd.dst;
          edge_weight_i <= next_cmd.weight;
          start_vertex_i <= next_cmd.start;
          next_valid = 1'b1;
        end
      end
      in_valid_i <= next_valid;
    end
  end

  always @(posedge clk_i) begin : drive_stall
    bit next_stall;
    next_stall = 1'b0;
    if (rst_ni) begin
      if (hold_left != 0) begin
        next_stall = 1'b1;
        hold_left <= hold_left - 1;
      end else if (hold_armed && !hold_taken && out_valid_o) begin
        next_stall = 1'b1;
        hold_left <= HOLD_CYCLES;
        hold_taken <= 1'b1;
      end else if (stall_left != 0) begin
        next_stall = 1'b1;
        stall_left <= stall_left - 1;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        next_stall = 1'b1;
        stall_left <= $urandom_range(0, 8);
      end
    end
    out_stall_i <= next_stall;
  end

  always @(posedge clk_i) begin : check_results
    vertex_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_vertices.size() == 0) begin
        $error("result transaction with nothing expected: vertex_index %0d", vertex_index_o);
        mismatch_count++;
      end else begin
        want = expected_vertices.pop_front();
        check_field("vertex_index", want.vertex, vertex_index_o);
        check_field("distance", want.distance, distance_o);
        check_field("predecessor", want.pred, predecessor_o);
        check_field("has_predecessor", want.has_pred, has_predecessor_o);
        check_field("reached", want.reached, reached_o);
        check_field("last", want.last, last_o);
      end
    end
  end

  task automatic push_cmd(input logic [1:0] op, input logic [VID_W-1:0] src,
                          input logic [VID_W-1:0] dst, input logic signed [15:0] weight,
                          input logic [VID_W-1:0] start);
    graph_cmd_t cmd;
    cmd.op = op;
    cmd.src = src;
    cmd.dst = dst;
    cmd.weight = weight;
    cmd.start = start;
    pending_cmds.push_back(cmd);
  endtask

  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_valid_i || expected_vertices.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input logic [ADDR_W-1:0] addr,
                            input logic [DATA_W-1:0] data, output logic [DATA_W-1:0] rdata);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= is_write;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    if (is_write && addr == VERTEX_COUNT_ADDR) vertex_cfg = data[CFG_W-1:0];
  endtask

  task automatic check_vertex_count();
    logic [DATA_W-1:0] rdata;
    apb_access(1'b0, VERTEX_COUNT_ADDR, '0, rdata);
    check_field("vertex_count", DATA_W'(vertex_cfg), rdata);
  endtask

  task automatic set_vertex_count(input int count);
    logic [DATA_W-1:0] data;
    logic [DATA_W-1:0] rdata;
    wait_idle();
    data = $urandom();
    data[CFG_W-1:0] = count[CFG_W-1:0];
    apb_access(1'b1, VERTEX_COUNT_ADDR, data, rdata);
    check_vertex_count();
  endtask

  function automatic logic [VID_W-1:0] pick_vertex(input int hi);
    if ($urandom_range(0, 7) == 0) return VID_W'($urandom);
    return VID_W'($urandom_range(0, hi));
  endfunction

  function automatic logic signed [15:0] pick_weight(input int mode);
    case (mode)
      0: return 16'($urandom_range(0, 1000));
      1: return 16'(int'($urandom_range(0, 1100)) - 100);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    int n;
    int k;
    int mode;
    int vtx_hi;
    int random_left;
    logic [DATA_W-1:0] scratch;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    check_vertex_count();
    push_cmd(OP_RUN, 6'h15, 6'h2a, 16'sh5a5a, 6'd0);
    push_cmd(OP_UNUSED, 6'h3f, 6'h3f, -16'sd1, 6'h3f);
    push_cmd(OP_APPEND, 6'd0, 6'd1, 16'sd32767, 6'h2a);
    push_cmd(OP_APPEND, 6'd1, 6'd2, -16'sd32768, 6'h15);
    push_cmd(OP_APPEND, 6'd2, 6'd63, 16'sd0, 6'h3f);
    push_cmd(OP_APPEND, 6'd63, 6'd63, -16'sd1, 6'h00);
    push_cmd(OP_APPEND, 6'd0, 6'd63, 16'sd100, 6'h2a);
    push_cmd(OP_APPEND, 6'd5, 6'd6, 16'sd7, 6'h15);
    push_cmd(OP_RUN, 6'h3f, 6'h00, 16'sh7fff, 6'd0);
    push_cmd(OP_RUN, 6'h00, 6'h3f, -16'sd32768, 6'd63);
    push_cmd(OP_APPEND, 6'd3, 6'd4, -16'sd32768, 6'h3f);
    push_cmd(OP_APPEND, 6'd4, 6'd3, -16'sd32768, 6'h00);
    push_cmd(OP_APPEND, 6'd0, 6'd3, 16'sd1, 6'h3f);
    push_cmd(OP_RUN, 6'h2a, 6'h15, 16'sh1234, 6'd0);
    push_cmd(OP_CLEAR, 6'h3f, 6'h3f, -16'sd1, 6'h3f);
    push_cmd(OP_UNUSED, 6'h00, 6'h00, 16'sd0, 6'h00);
    push_cmd(OP_RUN, 6'h11, 6'h22, 16'sh4321, 6'd5);

    set_vertex_count(5);
    push_cmd(OP_APPEND, 6'd1, 6'd7, 16'sd3, 6'h00);
    push_cmd(OP_APPEND, 6'd7, 6'd2, 16'sd3, 6'h00);
    push_cmd(OP_APPEND, 6'd0, 6'd4, -16'sd5, 6'h00);
    push_cmd(OP_APPEND, 6'd4, 6'd2, 16'sd2, 6'h00);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd7);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd0);

    set_vertex_count(0);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd0);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd1);
    set_vertex_count(127);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd0);
    wait_idle();
    apb_access(1'b1, SPARE_ADDR, 32'h0000_0003, scratch);
    check_vertex_count();
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd4);

    set_vertex_count(4);
    push_cmd(OP_CLEAR, 6'h00, 6'h00, 16'sd0, 6'h00);
    for (int i = 1; i <= 4; i++)
      push_cmd(OP_APPEND, 6'd0, VID_W'(i), -16'sd30000, 6'h00);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd0);
    set_vertex_count(GRAPH_VERTICES);
    push_cmd(OP_RUN, 6'h00, 6'h00, 16'sd0, 6'd0);
    push_cmd(OP_CLEAR, 6'h00, 6'h00, 16'sd0, 6'h00);

    hold_armed = 1'b1;
    random_left = 60;
    while (random_left > 0) begin
      case ($urandom_range(0, 9))
        0: n = 0;
        1: n = 1;
        2: n = GRAPH_VERTICES;
        3: n = 127;
        4: n = $urandom_range(2, 127);
        default: n = $urandom_range(2, 10);
      endcase
      set_vertex_count(n);
      quiet_phase = (random_left <= 25);
      vtx_hi = active_vertices() - 1;
      repeat (3) begin
        if (vtx_hi > 15 || $urandom_range(0, 2) == 0) begin
          push_cmd(OP_CLEAR, VID_W'($urandom), VID_W'($urandom), 16'($urandom),
                   VID_W'($urandom));
          random_left--;
        end
        k = $urandom_range(0, (vtx_hi > 15) ? 10 : 12);
        mode = $urandom_range(0, 2);
        repeat (k)
          push_cmd(OP_APPEND, pick_vertex(vtx_hi), pick_vertex(vtx_hi), pick_weight(mode),
                   VID_W'($urandom));
        if ($urandom_range(0, 3) == 0)
          push_cmd(OP_UNUSED, VID_W'($urandom), VID_W'($urandom), 16'($urandom),
                   VID_W'($urandom));
        push_cmd(OP_RUN, VID_W'($urandom), VID_W'($urandom), 16'($urandom),
                 pick_vertex(vtx_hi));
        random_left -= k + 1;
      end
    end

    wait_idle();
    if (mismatch_count == 0) begin
      $display("single_source_shortest_paths_unit regression: pass");
    end else begin
      $display("single_source_shortest_paths_unit regression: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("single_source_shortest_paths_unit regression: fail");
    $finish;
  end

endmodule
